### sv/ukn_pkg.sv
`timescale 1ns / 1ps

package ukn_pkg;

  localparam int unsigned CP_W = 21;

  // Code point bounds for the width and kana folding
  localparam logic [CP_W-1:0] FW_LO      = 21'h00FF01;
  localparam logic [CP_W-1:0] FW_HI      = 21'h00FF5E;
  localparam logic [CP_W-1:0] FW_OFFSET  = 21'h00FEE0;
  localparam logic [CP_W-1:0] IDEO_SPACE = 21'h003000;
  localparam logic [CP_W-1:0] ASCII_SP   = 21'h000020;
  localparam logic [CP_W-1:0] KANA_LO    = 21'h0030A1;
  localparam logic [CP_W-1:0] KANA_HI    = 21'h0030F6;
  localparam logic [CP_W-1:0] KANA_SHIFT = 21'h000060;

  // Lead byte classes
  localparam logic [7:0] LEAD2_BASE = 8'hC0;
  localparam logic [7:0] LEAD3_BASE = 8'hE0;
  localparam logic [7:0] LEAD4_BASE = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT = 8'hF8;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  // Continuation count of a byte; EXTRA_DROP marks a byte that is discarded
  localparam logic [2:0] EXTRA_NONE  = 3'd0;
  localparam logic [2:0] EXTRA_ONE   = 3'd1;
  localparam logic [2:0] EXTRA_TWO   = 3'd2;
  localparam logic [2:0] EXTRA_THREE = 3'd3;
  localparam logic [2:0] EXTRA_DROP  = 3'd4;

  // One decoded item's worth of output bytes, lowest index leaves first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
  } grp_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

  function automatic logic [2:0] lead_extra(input logic [7:0] c);
    logic [2:0] r;
    if (c[7] == 1'b0) begin
      r = EXTRA_NONE;
    end else if ((c & LEAD3_BASE) == LEAD2_BASE) begin
      r = EXTRA_ONE;
    end else if ((c & LEAD4_BASE) == LEAD3_BASE) begin
      r = EXTRA_TWO;
    end else if ((c & LEAD_LIMIT) == LEAD4_BASE) begin
      r = EXTRA_THREE;
    end else begin
      r = EXTRA_DROP;
    end
    return r;
  endfunction

  function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] r;
    r = cp;
    if (cp >= FW_LO && cp <= FW_HI) begin
      r = cp - FW_OFFSET;
    end else if (cp == IDEO_SPACE) begin
      r = ASCII_SP;
    end
    if (r >= KANA_LO && r <= KANA_HI) begin
      r = r - KANA_SHIFT;
    end
    return r;
  endfunction

  function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
    enc_t r;
    r.bytes = '0;
    if (cp < 21'h000080) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = 3'd1;
    end else if (cp < 21'h000800) begin
      r.bytes[0] = LEAD2_BASE | {3'b000, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp < 21'h010000) begin
      r.bytes[0] = LEAD3_BASE | {4'b0000, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      r.bytes[0] = LEAD4_BASE | {5'b00000, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

### sv/utf8_kana_width_normalizer_top.sv
`timescale 1ns / 1ps

// UTF-8 width and kana normalizer. Feed raw UTF-8 one byte per transaction on
// the in_ stream (tdata = byte, tlast = final byte of the text); normalized
// UTF-8 leaves one byte per transaction on the out_ stream. Decoding is
// lenient: a lead byte takes the next one to three bytes unchecked, stray
// continuation bytes and bytes F8-FF are dropped. Fullwidth ASCII FF01-FF5E
// becomes 21-7E, ideographic space becomes 20, katakana 30A1-30F6 moves down
// by 60 hex, and every code point is re-encoded in its shortest form. The
// input side takes one byte per cycle while out_tready is high and no byte
// yields more than one output byte. A byte goes from the input register
// through the combinational decoder into the group register, which drains
// one output byte per cycle, stalled only by out_tready; a byte that
// expands to several output bytes holds the input until its group drains.
// The final transaction of a text always carries out_tlast; when the last
// input produced no byte it is a bare marker with out_tuser low and
// out_tdata zero. A sequence cut short by the end of the text drops its
// lead and rescans the bytes held after it.
module utf8_kana_width_normalizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // has_byte
  output logic       out_tlast   // out_last
);
  import ukn_pkg::*;

  grp_t grp;
  logic grp_vld;
  logic grp_rdy;

  // Hold the lead state, decode and encode one byte per transaction
  ukn_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .grp_vld   (grp_vld),
    .grp_rdy   (grp_rdy),
    .grp       (grp)
  );

  // Drain each encoded group a byte at a time
  ukn_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_vld    (grp_vld),
    .grp_rdy    (grp_rdy),
    .grp        (grp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### sv/ukn_decode.sv
`timescale 1ns / 1ps

module ukn_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          grp_vld,
  input  logic          grp_rdy,
  output ukn_pkg::grp_t grp
);
  import ukn_pkg::*;

  logic            ivld_r;
  logic [7:0]      ibyte_r;
  logic            ilast_r;
  logic [7:0]      held_r [3];
  logic [1:0]      hcnt_r, hcnt_nxt;
  logic [1:0]      ncnt_r, ncnt_nxt;

  logic [2:0]      e_b, e_h, e_t0;
  logic            wr;
  logic [1:0]      widx;
  logic            main_vld;
  logic [CP_W-1:0] main_cp;
  logic [7:0]      h1, h2;
  logic            tail_en, len2;
  logic            a_vld, b_vld;
  logic [CP_W-1:0] a_cp;
  enc_t            enc;
  logic            take;

  always_comb begin
    e_b      = lead_extra(ibyte_r);
    e_h      = lead_extra(held_r[0]);
    wr       = 1'b0;
    widx     = 2'd0;
    main_vld = 1'b0;
    main_cp  = '0;
    hcnt_nxt = hcnt_r;
    ncnt_nxt = ncnt_r;
    if (hcnt_r == 2'd0) begin
      if (e_b == EXTRA_NONE) begin
        main_vld = 1'b1;
        main_cp  = {13'd0, ibyte_r};
      end else if (e_b != EXTRA_DROP) begin
        wr       = 1'b1;
        hcnt_nxt = 2'd1;
        ncnt_nxt = e_b[1:0];
      end
    end else if (ncnt_r <= 2'd1 || hcnt_r == 2'd3) begin
      // Sequence complete: fold the lead and continuations into one code point
      main_vld = 1'b1;
      case (e_h)
        EXTRA_ONE: main_cp = {10'd0, held_r[0][4:0], ibyte_r[5:0]};
        EXTRA_TWO: main_cp = {5'd0, held_r[0][3:0], held_r[1][5:0], ibyte_r[5:0]};
        default:   main_cp = {held_r[0][2:0], held_r[1][5:0], held_r[2][5:0],
                              ibyte_r[5:0]};
      endcase
      hcnt_nxt = 2'd0;
      ncnt_nxt = 2'd0;
    end else begin
      wr       = 1'b1;
      widx     = hcnt_r;
      hcnt_nxt = hcnt_r + 2'd1;
      ncnt_nxt = ncnt_r - 2'd1;
    end

    // Held bytes as they stand after this item
    h1 = (wr && widx == 2'd1) ? ibyte_r : held_r[1];
    h2 = (wr && widx == 2'd2) ? ibyte_r : held_r[2];

    // Rescan what follows a dropped lead at end of text
    tail_en = ilast_r && (hcnt_nxt > 2'd1);
    len2    = (hcnt_nxt == 2'd3);
    e_t0    = lead_extra(h1);
    a_vld   = 1'b0;
    a_cp    = '0;
    b_vld   = 1'b0;
    if (tail_en) begin
      if (e_t0 == EXTRA_NONE) begin
        a_vld = 1'b1;
        a_cp  = {13'd0, h1};
        b_vld = len2 && !h2[7];
      end else if (e_t0 == EXTRA_ONE && len2) begin
        a_vld = 1'b1;
        a_cp  = {10'd0, h1[4:0], h2[5:0]};
      end else begin
        b_vld = len2 && !h2[7];
      end
    end

    enc       = encode_cp(fold_cp(main_vld ? main_cp : a_cp));
    grp.bytes = enc.bytes;
    grp.cnt   = (main_vld || a_vld) ? enc.cnt : 3'd0;
    grp.last  = ilast_r;
    if (b_vld) begin
      grp.bytes[grp.cnt[1:0]] = h2;
      grp.cnt                 = grp.cnt + 3'd1;
    end
  end

  assign grp_vld   = ivld_r && (grp.cnt != 3'd0 || ilast_r);
  assign take      = ivld_r && (!grp_vld || grp_rdy);
  assign in_tready = !ivld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
      hcnt_r <= 2'd0;
      ncnt_r <= 2'd0;
    end else begin
      if (in_tready) begin
        ivld_r <= in_tvalid;
      end
      if (take) begin
        hcnt_r <= ilast_r ? 2'd0 : hcnt_nxt;
        ncnt_r <= ilast_r ? 2'd0 : ncnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ibyte_r <= in_tdata;
      ilast_r <= in_tlast;
    end
    if (take && wr) begin
      held_r[widx] <= ibyte_r;
    end
  end

endmodule

### sv/ukn_emit.sv
`timescale 1ns / 1ps

module ukn_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          grp_vld,
  output logic          grp_rdy,
  input  ukn_pkg::grp_t grp,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tuser,
  output logic          out_tlast
);
  import ukn_pkg::*;

  logic       gv_r;
  grp_t       g_r;
  logic [1:0] idx_r;
  logic       fin;

  // Final beat of the held group
  assign fin        = (g_r.cnt == 3'd0) || ({1'b0, idx_r} == g_r.cnt - 3'd1);
  assign grp_rdy    = !gv_r || (out_tready && fin);
  assign out_tvalid = gv_r;
  assign out_tuser  = (g_r.cnt != 3'd0);
  assign out_tdata  = out_tuser ? g_r.bytes[idx_r] : 8'd0;
  assign out_tlast  = g_r.last && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (grp_rdy) begin
      gv_r  <= grp_vld;
      idx_r <= 2'd0;
    end else if (out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_rdy && grp_vld) begin
      g_r <= grp;
    end
  end

endmodule

### sv/ukn_checker.sv
`timescale 1ns / 1ps

module ukn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // A stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output changed while stalled");

  // A bare end marker is always final and carries a zero byte
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("bad end marker");

  // Reset leaves the output empty and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset state wrong");

  // A valid output transaction carries a fully known payload
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tuser, out_tlast}))
    else $error("unknown output payload");

endmodule

bind utf8_kana_width_normalizer_top ukn_checker u_ukn_checker (.*);
